// ===== src/bale_pkg.sv =====
`timescale 1ns / 1ps

package bale_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;

  typedef enum logic [2:0] {
    CMD_INS_FRONT,
    CMD_INS_END,
    CMD_INS_ORDER,
    CMD_REM_FRONT,
    CMD_REM_END,
    CMD_REM_VALUE,
    CMD_SEARCH,
    CMD_NOP
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY,
    ST_NOT_FOUND
  } status_t;

  // What a cell loads at the next edge
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_LEFT,
    OP_RIGHT
  } cell_op_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   found_index;
    logic [CNT_W-1:0]   entry_count;
    logic               is_empty;
    logic               is_full;
  } result_t;

endpackage

// ===== src/bounded_array_list_engine_unit.sv =====
`timescale 1ns / 1ps
// The result is registered and shows on the output in the cycle after the input is accepted.
// Throughput: one command per cycle unless the input stalls; all list cells shift together.
// Input stalls only while a finished result waits on a stalled output.
// Reset: entry count cleared, capacity set to 16, output valid cleared.
// List entries are not cleared; only written entries are ever read.

module bounded_array_list_engine_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        command,
  input  logic signed [bale_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [bale_pkg::IDX_W-1:0]        found_index,
  output logic [bale_pkg::CNT_W-1:0]        entry_count,
  output logic                              is_empty,
  output logic                              is_full,
  input  logic                              cfg_wr_en,
  input  logic [bale_pkg::CAP_W-1:0]        cfg_wr_data
);

  logic                                       accept;
  logic [bale_pkg::CNT_W-1:0]                 count;
  logic [bale_pkg::CAP_W-1:0]                 capacity;
  logic [bale_pkg::DEPTH-1:0][bale_pkg::DATA_W-1:0] entries;
  logic [bale_pkg::DEPTH-1:0]                 eq;
  logic [bale_pkg::DEPTH-1:0]                 lt;
  bale_pkg::cell_op_t [bale_pkg::DEPTH-1:0]   ops;
  bale_pkg::result_t                          res;
  bale_pkg::result_t                          out_res;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  bale_ctrl u_ctrl (
    .cmd      (bale_pkg::cmd_t'(command)),
    .count    (count),
    .capacity (capacity),
    .eq       (eq),
    .lt       (lt),
    .ops      (ops),
    .res      (res)
  );

  for (genvar i = 0; i < bale_pkg::DEPTH; i++) begin : g_cell
    logic [bale_pkg::DATA_W-1:0] left_in;
    logic [bale_pkg::DATA_W-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = value;
    end else begin : g_mid_l
      assign left_in = entries[i-1];
    end

    // last cell has no right neighbor; it keeps its own word
    if (i == bale_pkg::DEPTH - 1) begin : g_last
      assign right_in = entries[i];
    end else begin : g_mid_r
      assign right_in = entries[i+1];
    end

    bale_cell u_cell (
      .clk   (clk),
      .en    (accept),
      .op    (ops[i]),
      .value (value),
      .left  (left_in),
      .right (right_in),
      .entry (entries[i]),
      .eq    (eq[i]),
      .lt    (lt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      capacity  <= bale_pkg::CAP_W'(bale_pkg::CAP_RESET);
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) capacity <= cfg_wr_data;
      if (accept) begin
        count     <= res.entry_count;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_res <= res;
  end

  assign status      = out_res.status;
  assign found_index = out_res.found_index;
  assign entry_count = out_res.entry_count;
  assign is_empty    = out_res.is_empty;
  assign is_full     = out_res.is_full;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bale_pkg::CNT_W'(bale_pkg::DEPTH))
    else $error("entry count above depth");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (rst)
    accept && res.status != bale_pkg::ST_OK |=> $stable(count))
    else $error("failed command changed the entry count");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && res.status == bale_pkg::ST_OK &&
    (command == bale_pkg::CMD_INS_FRONT || command == bale_pkg::CMD_INS_END ||
     command == bale_pkg::CMD_INS_ORDER)
    |=> count == $past(count) + 1'b1)
    else $error("successful insert did not grow the list by one");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && found_index != '0 |-> status == bale_pkg::ST_OK)
    else $error("nonzero found index with failing status");

endmodule

// ===== src/bale_cell.sv =====
`timescale 1ns / 1ps

module bale_cell (
  input  logic                              clk,
  input  logic                              en,
  input  bale_pkg::cell_op_t                op,
  input  logic signed [bale_pkg::DATA_W-1:0] value,
  input  logic        [bale_pkg::DATA_W-1:0] left,
  input  logic        [bale_pkg::DATA_W-1:0] right,
  output logic        [bale_pkg::DATA_W-1:0] entry,
  output logic                              eq,
  output logic                              lt
);

  assign eq = (entry == value);
  assign lt = ($signed(entry) < value);

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (op)
        bale_pkg::OP_HOLD:  entry <= entry;
        bale_pkg::OP_LOAD:  entry <= value;
        bale_pkg::OP_LEFT:  entry <= left;
        bale_pkg::OP_RIGHT: entry <= right;
        default:            entry <= entry;
      endcase
    end
  end

endmodule

// ===== src/bale_ctrl.sv =====
`timescale 1ns / 1ps

module bale_ctrl (
  input  bale_pkg::cmd_t                              cmd,
  input  logic [bale_pkg::CNT_W-1:0]                  count,
  input  logic [bale_pkg::CAP_W-1:0]                  capacity,
  input  logic [bale_pkg::DEPTH-1:0]                  eq,
  input  logic [bale_pkg::DEPTH-1:0]                  lt,
  output bale_pkg::cell_op_t [bale_pkg::DEPTH-1:0]    ops,
  output bale_pkg::result_t                           res
);

  localparam int CMP_W = bale_pkg::CNT_W + bale_pkg::CAP_W;

  function automatic logic full_f(input logic [bale_pkg::CNT_W-1:0] cnt,
                                  input logic [bale_pkg::CAP_W-1:0] cap);
    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] cap_x;
    logic [CMP_W-1:0] dep_x;
    logic [CMP_W-1:0] eff;
    cnt_x = CMP_W'(cnt);
    cap_x = CMP_W'(cap);
    dep_x = CMP_W'(bale_pkg::DEPTH);
    eff   = (cap_x > dep_x) ? dep_x : cap_x;
    return cnt_x >= eff;
  endfunction

  logic [bale_pkg::DEPTH-1:0] live;
  logic [bale_pkg::DEPTH-1:0] match;
  logic [bale_pkg::DEPTH-1:0] below;
  logic [bale_pkg::IDX_W-1:0] first;
  logic [bale_pkg::CNT_W-1:0] place;
  logic                       found;
  logic                       full_now;
  logic                       empty_now;
  logic [bale_pkg::CNT_W-1:0] cnt_next;
  bale_pkg::status_t          status;
  logic [bale_pkg::IDX_W-1:0] fidx;

  always_comb begin
    for (int i = 0; i < bale_pkg::DEPTH; i++) begin
      live[i] = (bale_pkg::CNT_W'(i) < count);
    end
    match = eq & live;
    below = lt & live;
    found = |match;

    first = '0;
    for (int i = bale_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match[i]) first = bale_pkg::IDX_W'(i);
    end

    // ordered insert goes just after the last live entry smaller than the value
    place = '0;
    for (int i = 0; i < bale_pkg::DEPTH; i++) begin
      if (below[i]) place = bale_pkg::CNT_W'(i + 1);
    end
  end

  assign full_now  = full_f(count, capacity);
  assign empty_now = (count == '0);

  always_comb begin
    for (int i = 0; i < bale_pkg::DEPTH; i++) ops[i] = bale_pkg::OP_HOLD;
    status   = bale_pkg::ST_OK;
    fidx     = '0;
    cnt_next = count;

    unique case (cmd)
      bale_pkg::CMD_INS_FRONT: begin
        if (full_now) begin
          status = bale_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < bale_pkg::DEPTH; i++) begin
            if (i == 0) ops[i] = bale_pkg::OP_LOAD;
            else if (bale_pkg::CNT_W'(i) <= count) ops[i] = bale_pkg::OP_LEFT;
          end
          cnt_next = count + 1'b1;
        end
      end
      bale_pkg::CMD_INS_END: begin
        if (full_now) begin
          status = bale_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < bale_pkg::DEPTH; i++) begin
            if (bale_pkg::CNT_W'(i) == count) ops[i] = bale_pkg::OP_LOAD;
          end
          cnt_next = count + 1'b1;
        end
      end
      bale_pkg::CMD_INS_ORDER: begin
        if (full_now) begin
          status = bale_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < bale_pkg::DEPTH; i++) begin
            if (bale_pkg::CNT_W'(i) == place) ops[i] = bale_pkg::OP_LOAD;
            else if (bale_pkg::CNT_W'(i) > place && bale_pkg::CNT_W'(i) <= count)
              ops[i] = bale_pkg::OP_LEFT;
          end
          cnt_next = count + 1'b1;
        end
      end
      bale_pkg::CMD_REM_FRONT: begin
        if (empty_now) begin
          status = bale_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < bale_pkg::DEPTH; i++) begin
            if (live[i]) ops[i] = bale_pkg::OP_RIGHT;
          end
          cnt_next = count - 1'b1;
        end
      end
      bale_pkg::CMD_REM_END: begin
        if (empty_now) status = bale_pkg::ST_EMPTY;
        else cnt_next = count - 1'b1;
      end
      bale_pkg::CMD_REM_VALUE: begin
        if (empty_now) begin
          status = bale_pkg::ST_EMPTY;
        end else if (!found) begin
          status = bale_pkg::ST_NOT_FOUND;
        end else begin
          for (int i = 0; i < bale_pkg::DEPTH; i++) begin
            if (live[i] && bale_pkg::IDX_W'(i) >= first) ops[i] = bale_pkg::OP_RIGHT;
          end
          cnt_next = count - 1'b1;
        end
      end
      bale_pkg::CMD_SEARCH: begin
        if (empty_now) status = bale_pkg::ST_EMPTY;
        else if (!found) status = bale_pkg::ST_NOT_FOUND;
        else fidx = first;
      end
      bale_pkg::CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.status      = status;
    res.found_index = fidx;
    res.entry_count = cnt_next;
    res.is_empty    = (cnt_next == '0);
    res.is_full     = full_f(cnt_next, capacity);
  end

endmodule

// ===== sim/bounded_array_list_engine_unit_test.sv =====
`timescale 1ns / 1ps

module bounded_array_list_engine_unit_test;
  import bale_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    bit                       set_cap;
    logic [CAP_W-1:0]         cap;
    logic [2:0]               cmd;
    logic signed [DATA_W-1:0] val;
    bit                       known;
    result_t                  res;
  } list_txn_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [2:0]                command = 3'd0;
  logic signed [DATA_W-1:0]  value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                status;
  logic [IDX_W-1:0]          found_index;
  logic [CNT_W-1:0]          entry_count;
  logic                      is_empty;
  logic                      is_full;
  logic                      cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]          cfg_wr_data = '0;

  // Shadow copy of the list
  logic signed [DATA_W-1:0]  shadow_list [0:DEPTH-1];
  int                        shadow_len = 0;
  logic [CAP_W-1:0]          shadow_cap = CAP_RESET;

  list_txn_t                 dir_tab [$];
  list_txn_t                 cmd_q [$];
  result_t                   expected_results [$];

  int                        fail_cnt = 0;
  int                        cycle_cnt = 0;
  int                        burst_left = 0;
  int                        gap_left = 0;
  int                        stall_left = 0;
  int                        stall_mode = 0;

  bounded_array_list_engine_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_index (found_index),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t apply_list_cmd(input logic [2:0] op,
                                             input logic signed [DATA_W-1:0] operand);
    result_t r;
    int      lim;
    int      i;
    int      pos;
    int      place;
    bit      stop;
    lim = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
    r.status = ST_OK;
    r.found_index = '0;
    pos = -1;
    if (op == CMD_REM_VALUE || op == CMD_SEARCH) begin
      for (i = 0; i < shadow_len; i++)
        if (pos < 0 && shadow_list[i] == operand) pos = i;
    end
    case (op)
      CMD_INS_FRONT, CMD_INS_END, CMD_INS_ORDER: begin
        if (shadow_len >= lim) begin
          r.status = ST_FULL;
        end else if (op == CMD_INS_FRONT) begin
          for (i = shadow_len; i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = operand;
          shadow_len++;
        end else if (op == CMD_INS_END) begin
          shadow_list[shadow_len] = operand;
          shadow_len++;
        end else begin
          // walk down from the tail, shifting up everything not smaller
          place = 0;
          stop = 1'b0;
          for (i = shadow_len; i > 0; i--) begin
            if (!stop) begin
              if (operand > shadow_list[i-1]) begin
                place = i;
                stop = 1'b1;
              end else begin
                shadow_list[i] = shadow_list[i-1];
              end
            end
          end
          shadow_list[place] = operand;
          shadow_len++;
        end
      end
      CMD_REM_FRONT, CMD_REM_END, CMD_REM_VALUE, CMD_SEARCH: begin
        // empty wins over not-found
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (op == CMD_REM_END) begin
          shadow_len--;
        end else if (op == CMD_REM_FRONT || (op == CMD_REM_VALUE && pos >= 0)) begin
          if (op == CMD_REM_FRONT) pos = 0;
          for (i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end else if (pos < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found_index = pos[IDX_W-1:0];
        end
      end
      default: begin
      end
    endcase
    r.entry_count = shadow_len[CNT_W-1:0];
    r.is_empty = (shadow_len == 0);
    r.is_full = (shadow_len >= lim);
    return r;
  endfunction

  task automatic flag_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic put_row(input logic [2:0] c, input logic [DATA_W-1:0] v);
    list_txn_t t;
    t.set_cap = 1'b0;
    t.cap = '0;
    t.cmd = c;
    t.val = v;
    t.known = 1'b0;
    t.res = '0;
    dir_tab.push_back(t);
  endtask

  task automatic put_known(input logic [2:0] c, input logic [DATA_W-1:0] v,
                           input status_t s, input int cnt, input bit emp, input bit ful);
    list_txn_t t;
    t.set_cap = 1'b0;
    t.cap = '0;
    t.cmd = c;
    t.val = v;
    t.known = 1'b1;
    t.res.status = s;
    t.res.found_index = '0;
    t.res.entry_count = cnt[CNT_W-1:0];
    t.res.is_empty = emp;
    t.res.is_full = ful;
    dir_tab.push_back(t);
  endtask

  task automatic put_cap(input logic [CAP_W-1:0] c);
    list_txn_t t;
    t = '{default: '0};
    t.set_cap = 1'b1;
    t.cap = c;
    dir_tab.push_back(t);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (cmd_q.size() != 0 || in_valid || expected_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= c;
    shadow_cap = c;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic queue_random_cmds(input int n, input int ins_pct);
    logic [DATA_W-1:0] pool [0:5];
    list_txn_t         t;
    int                i;
    int                r;
    for (i = 0; i < 6; i++) begin
      r = $urandom_range(0, 9);
      if (r == 0) pool[i] = 32'h8000_0000;
      else if (r == 1) pool[i] = 32'h7fff_ffff;
      else if (r == 2) pool[i] = $urandom();
      else pool[i] = $urandom_range(0, 20) - 10;
    end
    t = '{default: '0};
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) t.cmd = 3'($urandom_range(0, 2));
      else if (r < 97) t.cmd = 3'($urandom_range(3, 6));
      else t.cmd = CMD_NOP;
      t.val = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 5)] : $urandom();
      cmd_q.push_back(t);
    end
  endtask

  // Sender: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    list_txn_t cur;
    result_t   r;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        cur = cmd_q.pop_front();
        r = apply_list_cmd(cur.cmd, cur.val);
        expected_results.push_back(cur.known ? cur.res : r);
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() != 0) begin
          in_valid <= 1'b1;
          command <= cmd_q[0].cmd;
          value <= cmd_q[0].val;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 10);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern drawn from four modes, redrawn at random intervals
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 80);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= (stall_left % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        flag_failure("result transaction with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (status != want.status || found_index != want.found_index ||
            entry_count != want.entry_count || is_empty != want.is_empty ||
            is_full != want.is_full)
          flag_failure($sformatf(
            "exp st=%0d idx=%0d cnt=%0d emp=%0b full=%0b got st=%0d idx=%0d cnt=%0d emp=%0b full=%0b",
            want.status, want.found_index, want.entry_count, want.is_empty, want.is_full,
            status, found_index, entry_count, is_empty, is_full));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [CAP_W-1:0] caps [0:11];
    int               i;
    caps = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd5, 5'd2, 5'd16, 5'd3, 5'd8, 5'd31, 5'd16};

    // empty-list checks first: status empty beats not-found
    put_known(CMD_SEARCH, 5, ST_EMPTY, 0, 1, 0);
    put_known(CMD_REM_FRONT, 0, ST_EMPTY, 0, 1, 0);
    put_known(CMD_REM_END, 0, ST_EMPTY, 0, 1, 0);
    put_known(CMD_REM_VALUE, 0, ST_EMPTY, 0, 1, 0);
    put_known(CMD_NOP, 32'hffff_ffff, ST_OK, 0, 1, 0);
    put_known(CMD_INS_END, 32'h7fff_ffff, ST_OK, 1, 0, 0);
    put_known(CMD_INS_FRONT, 32'h8000_0000, ST_OK, 2, 0, 0);
    put_row(CMD_INS_ORDER, 0);
    put_row(CMD_INS_ORDER, 32'hffff_ffff);
    put_row(CMD_INS_ORDER, 0);
    put_row(CMD_INS_ORDER, 32'h8000_0000);
    put_row(CMD_SEARCH, 0);
    put_row(CMD_SEARCH, 32'h7fff_ffff);
    put_known(CMD_SEARCH, 123, ST_NOT_FOUND, 6, 0, 0);
    put_row(CMD_REM_VALUE, 0);
    put_known(CMD_REM_VALUE, 32'h55, ST_NOT_FOUND, 5, 0, 0);
    put_row(CMD_REM_FRONT, 0);
    put_row(CMD_REM_END, 0);
    // capacity dropped under the current count
    put_cap(2);
    put_known(CMD_INS_FRONT, 7, ST_FULL, 3, 0, 1);
    put_known(CMD_INS_ORDER, 7, ST_FULL, 3, 0, 1);
    put_row(CMD_REM_FRONT, 0);
    put_known(CMD_REM_END, 0, ST_OK, 1, 0, 0);
    put_known(CMD_INS_END, 9, ST_OK, 2, 0, 1);
    // zero capacity: always full
    put_cap(0);
    put_known(CMD_INS_END, 1, ST_FULL, 2, 0, 1);
    put_known(CMD_REM_END, 0, ST_OK, 1, 0, 1);
    put_known(CMD_REM_FRONT, 0, ST_OK, 0, 1, 1);
    put_known(CMD_INS_FRONT, 1, ST_FULL, 0, 1, 1);
    put_known(CMD_SEARCH, 1, ST_EMPTY, 0, 1, 1);
    // saturates at the list depth
    put_cap(31);
    put_known(CMD_NOP, 0, ST_OK, 0, 1, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].set_cap) begin
        wait_idle();
        write_capacity(dir_tab[i].cap);
      end else begin
        cmd_q.push_back(dir_tab[i]);
      end
    end

    for (i = 0; i < 12; i++) begin
      wait_idle();
      write_capacity((i == 7) ? 5'($urandom_range(1, 16)) : caps[i]);
      queue_random_cmds(100, (i % 2 == 0) ? 70 : 35);
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (expected_results.size() != 0)
      flag_failure($sformatf("%0d results never arrived", expected_results.size()));
    if (fail_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
